[rtl/core/tkc_pkg.sv]
// tkc_pkg: shared types and constants of the touch key conditioner
// payload structs, action codes, register indexes, controller/datapath links
// no dependencies
package tkc_pkg;

    // one scan sample of the four touch lines
    typedef struct packed {
        logic touch_reset;
        logic touch_confirm;
        logic touch_prev;
        logic touch_next;
    } t_smp;

    // one conditioned result
    typedef struct packed {
        logic [2:0] action;
        logic       confirm_press;
        logic       next_press;
        logic       prev_press;
        logic [6:0] progress_level;
    } t_res;

    localparam logic [2:0] ACT_NORMAL   = 3'd0;
    localparam logic [2:0] ACT_WAKE     = 3'd1;
    localparam logic [2:0] ACT_IDLE     = 3'd2;
    localparam logic [2:0] ACT_QUIET    = 3'd3;
    localparam logic [2:0] ACT_PROGRESS = 3'd4;
    localparam logic [2:0] ACT_FIRE     = 3'd5;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REP_INT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET     = 3'd5;

    localparam logic [6:0] PCT_FULL = 7'd100;

    // shared divider: dividend up to 1000 * 100, divisor up to 10 bits
    localparam int DVD_W = 17;
    localparam int DVS_W = 10;

    typedef struct packed {
        logic accept;
        logic eval;
        logic launch;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic job_any;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[rtl/core/tkc_div.sv]
// tkc_div: restoring divider, one quotient bit per cycle
// depends on tkc_pkg for operand widths
module tkc_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tkc_pkg::DVD_W-1:0] i_dvd,
    input  logic [tkc_pkg::DVS_W-1:0] i_dvs,
    output logic                      o_done,
    output logic [tkc_pkg::DVD_W-1:0] o_quo,
    output logic [tkc_pkg::DVS_W-1:0] o_rem
);
    import tkc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        shifted = {r_rem, r_quo[DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W - 1);
            n_quo  = i_dvd;
            n_rem  = '0;
            n_dvs  = i_dvs;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = diff[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

[rtl/core/tkc_dp.sv]
// tkc_dp: datapath of the touch key conditioner
// key state, config registers, job queue for the divider, output register
// depends on tkc_pkg and tkc_div
module tkc_dp #(
    parameter int RESET_HOLD_CAP = 1000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tkc_pkg::t_cmd                 i_cmd,
    output tkc_pkg::t_sts                 o_sts,
    input  tkc_pkg::t_smp                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tkc_pkg::t_res                 o_out,
    input  logic                          i_cfg_we,
    input  logic [tkc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tkc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import tkc_pkg::*;

    localparam int K_RST  = 0;
    localparam int K_OK   = 1;
    localparam int K_PREV = 2;
    localparam int K_NEXT = 3;

    typedef enum logic [1:0] {
        JOB_NXT = 2'd0,
        JOB_PRV = 2'd1,
        JOB_PCT = 2'd2
    } t_job;

    typedef struct packed {
        logic [15:0] rc;
        logic        press;
        logic        job;
        logic [15:0] dvd;
    } t_rep;

    // auto-repeat step for one key, on its freshly debounced state
    function automatic t_rep f_rep(input logic chg, input logic lvl, input logic [7:0] cnt,
                                   input logic [15:0] rc, input logic [7:0] db,
                                   input logic [9:0] frd);
        t_rep        r;
        logic [15:0] h;
        r       = '0;
        r.rc    = chg ? 16'd0 : rc;
        h       = r.rc + 16'd1;
        r.dvd   = h - {6'd0, frd};
        if (lvl && cnt == db) begin
            r.rc    = 16'd0;
            r.press = 1'b1;
        end else if (lvl && cnt > db) begin
            r.rc = h;
            if (h == {6'd0, frd}) begin
                r.press = 1'b1;
            end else if (h > {6'd0, frd}) begin
                r.job = 1'b1;
            end
        end
        return r;
    endfunction

    // config registers
    logic [7:0]  r_cfg_db;
    logic [9:0]  r_cfg_hold;
    logic [15:0] r_cfg_idle;
    logic [9:0]  r_cfg_frd;
    logic [9:0]  r_cfg_rint;
    logic [7:0]  r_cfg_quiet;

    // key state
    logic        r_idle, n_idle;
    logic [15:0] r_ic, n_ic;
    logic [3:0]  r_lvl, n_lvl;
    logic [7:0]  r_cnt [4];
    logic [7:0]  n_cnt [4];
    logic [15:0] r_rc [2];
    logic [15:0] n_rc [2];
    logic [9:0]  r_hold, n_hold;
    logic        r_latch, n_latch;
    logic [7:0]  r_quiet, n_quiet;

    // sample and result under construction
    t_smp        r_smp;
    logic [2:0]  r_act, n_act;
    logic        r_pok, n_pok;
    logic        r_pnx, n_pnx;
    logic        r_ppv, n_ppv;
    logic [6:0]  r_level, n_level;
    logic        r_job_nxt, n_job_nxt;
    logic        r_job_prv, n_job_prv;
    logic        r_job_pct, n_job_pct;
    logic [15:0] r_nxt_dvd, n_nxt_dvd;
    logic [15:0] r_prv_dvd, n_prv_dvd;
    logic [DVD_W-1:0] r_pct_dvd, n_pct_dvd;
    t_job        r_job_cur;

    t_res        r_out;
    logic        r_out_vld;

    // evaluation temporaries
    logic [3:0]  smp;
    logic        any;
    logic [15:0] ic_step;
    logic [3:0]  chg;
    logic [3:0]  lvl_d;
    logic [7:0]  cnt_d [4];
    t_rep        rep_nx, rep_pv;
    logic        rst_act;
    logic [9:0]  hold_inc;
    logic        ok_press;

    // divider hookup
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [DVS_W-1:0] div_rem;
    logic [DVS_W-1:0] rint_eff;

    always_comb begin
        smp[K_RST]  = r_smp.touch_reset;
        smp[K_OK]   = r_smp.touch_confirm;
        smp[K_PREV] = r_smp.touch_prev;
        smp[K_NEXT] = r_smp.touch_next;
        any = |smp;
        if (any) begin
            ic_step = 16'd0;
        end else if (r_ic != 16'hFFFF) begin
            ic_step = r_ic + 16'd1;
        end else begin
            ic_step = r_ic;
        end
        for (int k = 0; k < 4; k++) begin
            chg[k] = smp[k] != r_lvl[k];
            lvl_d[k] = smp[k];
            if (chg[k]) begin
                cnt_d[k] = 8'd0;
            end else if (r_cnt[k] != 8'hFF) begin
                cnt_d[k] = r_cnt[k] + 8'd1;
            end else begin
                cnt_d[k] = r_cnt[k];
            end
        end
        ok_press = lvl_d[K_OK] && cnt_d[K_OK] == r_cfg_db;
        rep_nx = f_rep(chg[K_NEXT], lvl_d[K_NEXT], cnt_d[K_NEXT], r_rc[1], r_cfg_db, r_cfg_frd);
        rep_pv = f_rep(chg[K_PREV], lvl_d[K_PREV], cnt_d[K_PREV], r_rc[0], r_cfg_db, r_cfg_frd);
        rst_act  = lvl_d[K_RST] && cnt_d[K_RST] >= r_cfg_db;
        hold_inc = (r_hold < 10'(RESET_HOLD_CAP)) ? r_hold + 10'd1 : r_hold;

        n_idle    = r_idle;
        n_ic      = r_ic;
        n_lvl     = r_lvl;
        n_cnt     = r_cnt;
        n_rc      = r_rc;
        n_hold    = r_hold;
        n_latch   = r_latch;
        n_quiet   = r_quiet;
        n_act     = ACT_NORMAL;
        n_pok     = 1'b0;
        n_pnx     = 1'b0;
        n_ppv     = 1'b0;
        n_level   = 7'd0;
        n_job_nxt = 1'b0;
        n_job_prv = 1'b0;
        n_job_pct = 1'b0;
        n_nxt_dvd = rep_nx.dvd;
        n_prv_dvd = rep_pv.dvd;
        n_pct_dvd = DVD_W'(hold_inc) * DVD_W'(PCT_FULL);

        if (!r_idle) begin
            n_ic = ic_step;
        end
        if (r_idle && any) begin
            n_idle = 1'b0;
            n_ic   = 16'd0;
            n_act  = ACT_WAKE;
        end else if (!r_idle && ic_step >= r_cfg_idle) begin
            n_idle = 1'b1;
            n_act  = ACT_IDLE;
        end else if (r_quiet != 8'd0) begin
            n_quiet = r_quiet - 8'd1;
            n_lvl   = '0;
            n_cnt   = '{default: 8'd0};
            n_rc    = '{default: 16'd0};
            n_hold  = 10'd0;
            n_act   = ACT_QUIET;
        end else begin
            n_lvl   = lvl_d;
            n_cnt   = cnt_d;
            n_rc[1] = rep_nx.rc;
            n_rc[0] = rep_pv.rc;
            if (rst_act) begin
                n_hold = hold_inc;
                if (!r_latch && hold_inc >= r_cfg_hold) begin
                    n_quiet = r_cfg_quiet;
                    n_lvl   = '0;
                    n_cnt   = '{default: 8'd0};
                    n_rc    = '{default: 16'd0};
                    n_hold  = 10'd0;
                    n_latch = 1'b1;
                    n_act   = ACT_FIRE;
                    n_level = PCT_FULL;
                end else begin
                    n_act = ACT_PROGRESS;
                    if (r_cfg_hold == 10'd0) begin
                        n_level = PCT_FULL;
                    end else begin
                        n_job_pct = 1'b1;
                    end
                end
            end else begin
                n_hold    = 10'd0;
                n_latch   = 1'b0;
                n_pok     = ok_press;
                n_pnx     = rep_nx.press;
                n_ppv     = rep_pv.press;
                n_job_nxt = rep_nx.job;
                n_job_prv = rep_pv.job;
            end
        end
    end

    // next job for the divider: next, then prev, then percent
    assign rint_eff = (r_cfg_rint == 10'd0) ? 10'd1 : r_cfg_rint;
    always_comb begin
        if (r_job_nxt) begin
            div_dvd = DVD_W'(r_nxt_dvd);
            div_dvs = rint_eff;
        end else if (r_job_prv) begin
            div_dvd = DVD_W'(r_prv_dvd);
            div_dvs = rint_eff;
        end else begin
            div_dvd = r_pct_dvd;
            div_dvs = r_cfg_hold;
        end
    end

    tkc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.launch),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_db    <= 8'd3;
            r_cfg_hold  <= 10'd60;
            r_cfg_idle  <= 16'd2400;
            r_cfg_frd   <= 10'd25;
            r_cfg_rint  <= 10'd20;
            r_cfg_quiet <= 8'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:  r_cfg_db    <= i_cfg_data[7:0];
                CFG_HOLD:      r_cfg_hold  <= i_cfg_data[9:0];
                CFG_IDLE:      r_cfg_idle  <= i_cfg_data;
                CFG_FIRST_REP: r_cfg_frd   <= i_cfg_data[9:0];
                CFG_REP_INT:   r_cfg_rint  <= i_cfg_data[9:0];
                CFG_QUIET:     r_cfg_quiet <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle    <= 1'b1;
            r_ic      <= 16'd0;
            r_lvl     <= '0;
            r_cnt     <= '{default: 8'd0};
            r_rc      <= '{default: 16'd0};
            r_hold    <= 10'd0;
            r_latch   <= 1'b0;
            r_quiet   <= 8'd0;
            r_job_nxt <= 1'b0;
            r_job_prv <= 1'b0;
            r_job_pct <= 1'b0;
            r_job_cur <= JOB_NXT;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_idle    <= n_idle;
                r_ic      <= n_ic;
                r_lvl     <= n_lvl;
                r_cnt     <= n_cnt;
                r_rc      <= n_rc;
                r_hold    <= n_hold;
                r_latch   <= n_latch;
                r_quiet   <= n_quiet;
                r_job_nxt <= n_job_nxt;
                r_job_prv <= n_job_prv;
                r_job_pct <= n_job_pct;
            end else if (i_cmd.launch) begin
                if (r_job_nxt) begin
                    r_job_nxt <= 1'b0;
                    r_job_cur <= JOB_NXT;
                end else if (r_job_prv) begin
                    r_job_prv <= 1'b0;
                    r_job_cur <= JOB_PRV;
                end else begin
                    r_job_pct <= 1'b0;
                    r_job_cur <= JOB_PCT;
                end
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_smp <= i_in;
        end
        if (i_cmd.eval) begin
            r_act     <= n_act;
            r_pok     <= n_pok;
            r_pnx     <= n_pnx;
            r_ppv     <= n_ppv;
            r_level   <= n_level;
            r_nxt_dvd <= n_nxt_dvd;
            r_prv_dvd <= n_prv_dvd;
            r_pct_dvd <= n_pct_dvd;
        end else if (div_done) begin
            case (r_job_cur)
                JOB_NXT: r_pnx <= div_rem == '0;
                JOB_PRV: r_ppv <= div_rem == '0;
                default: begin
                    r_level <= (div_quo > DVD_W'(PCT_FULL)) ? PCT_FULL : div_quo[6:0];
                end
            endcase
        end
        if (i_cmd.load_out) begin
            r_out.action         <= r_act;
            r_out.confirm_press  <= r_pok;
            r_out.next_press     <= r_pnx;
            r_out.prev_press     <= r_ppv;
            r_out.progress_level <= r_level;
        end
    end

    assign o_sts.job_any  = r_job_nxt | r_job_prv | r_job_pct;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out          = r_out;

endmodule

[rtl/core/tkc_ctrl.sv]
// tkc_ctrl: sequencer of the touch key conditioner
// steps one request through evaluate, divider jobs and output load
// depends on tkc_pkg
module tkc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output tkc_pkg::t_cmd o_cmd,
    input  tkc_pkg::t_sts i_sts
);
    import tkc_pkg::*;

    typedef enum logic [4:0] {
        S_WAIT   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_DIV    = 5'b01000,
        S_OUT    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_WAIT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_LAUNCH;
            end
            S_LAUNCH: begin
                if (i_sts.job_any) begin
                    o_cmd.launch = 1'b1;
                    n_state      = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_LAUNCH;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_WAIT;
                end
            end
            default: n_state = S_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/core/touch_key_conditioner_top.sv]
// touch_key_conditioner_top: debounce, auto-repeat and long-press reset for four touch keys
// channel       | handshake                  | payload
// sample in     | i_in_valid / o_in_ready    | i_in  (tkc_pkg::t_smp)
// result out    | o_out_valid / i_out_ready  | o_out (tkc_pkg::t_res)
// config write  | i_cfg_we                   | i_cfg_idx, i_cfg_data
// one request at a time: accept, evaluate, divider jobs if any, then the output load;
// the jobs are the percent level alone or one or two repeat checks, run one after another
// each job: launch state, the 17 steps of the shared restoring divider, done strobe
// a new request is taken while the previous result still waits in the output register
// reset is synchronous, active low; state, config and flags reset, payload registers do not
module touch_key_conditioner_top #(
    parameter int RESET_HOLD_CAP = 1000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tkc_pkg::t_smp                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tkc_pkg::t_res                 o_out,
    input  logic                          i_cfg_we,
    input  logic [tkc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tkc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import tkc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tkc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    tkc_dp #(
        .RESET_HOLD_CAP (RESET_HOLD_CAP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

[rtl/core/tkc_chk.sv]
// tkc_chk: port-level checks of the touch key conditioner, bound to the top level
// depends on tkc_pkg
module tkc_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input tkc_pkg::t_res o_out,
    input logic          i_cfg_we
);
    import tkc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // press events only with action normal
    a_press_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.action != ACT_NORMAL |->
            !(o_out.confirm_press || o_out.next_press || o_out.prev_press))
        else $error("press event outside normal action");

    // progress level only with progress or fire, full on fire
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out.action == ACT_FIRE && o_out.progress_level == PCT_FULL) ||
            (o_out.action == ACT_PROGRESS && o_out.progress_level <= PCT_FULL) ||
            (o_out.action != ACT_FIRE && o_out.action != ACT_PROGRESS &&
             o_out.progress_level == 7'd0))
        else $error("bad progress level");

    // one request in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    // config writes must land only while the block is empty; the block does not enforce it, this check flags it
    a_cfg_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_in_ready && !o_out_valid)
        else $error("config written while a request is in flight");

endmodule

bind touch_key_conditioner_top tkc_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .i_cfg_we    (i_cfg_we)
);
